// ===== rtl/scca_pkg.sv =====
// Package for the size class chunk allocator.
// Holds word types, status and command codes, class sizes and the size-to-class map.
// No dependencies.
`default_nettype none

package scca_pkg;

  localparam int ADDR_W      = 18;
  localparam int NUM_CLASSES = 7;
  localparam int CLS_W       = 3;
  localparam int SZ_W        = 11;

  localparam logic [SZ_W-1:0] HDR_BYTES = 11'h010;
  localparam logic [31:0]     MAX_CHUNK = 32'h0000_0550;

  localparam logic [SZ_W-1:0] CLASS_BYTES [NUM_CLASSES] = '{
    11'h010, 11'h030, 11'h050, 11'h0f0, 11'h110, 11'h330, 11'h550
  };

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [2:0] ST_GIVEN      = 3'd0;
  localparam logic [2:0] ST_SPLIT      = 3'd1;
  localparam logic [2:0] ST_TOO_LARGE  = 3'd2;
  localparam logic [2:0] ST_FREED      = 3'd3;
  localparam logic [2:0] ST_PAGE_FREE  = 3'd4;
  localparam logic [2:0] ST_FULL       = 3'd5;

  typedef struct packed {
    logic              cmd;
    logic [31:0]       alloc_bytes;
    logic [ADDR_W-1:0] free_addr;
    logic [5:0]        spare_page;
  } req_word_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [ADDR_W-1:0] chunk_addr;
    logic [CLS_W-1:0]  size_class;
  } rsp_word_t;

  function automatic logic [CLS_W-1:0] class_of(input logic [31:0] size);
    logic [CLS_W-1:0] c;
    c = CLS_W'(NUM_CLASSES - 1);
    for (int i = NUM_CLASSES - 2; i >= 0; i--) begin
      if (size <= 32'(CLASS_BYTES[i])) begin
        c = CLS_W'(i);
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/size_class_chunk_allocator_unit.sv =====
// Top level of the size class chunk allocator.
// Free stacks and page class tags live in two internal synchronous memories.
// Depends on scca_pkg.
`default_nettype none

// Seven segregated free stacks (16 to 1360 bytes) share one stack memory laid
// out as {class, index}; a second memory holds the class tag of each heap page.
// One word is worked at a time. Allocate from a non-empty class: stack read, then
// answer. Too large: answer only. Free: page number by a reciprocal multiply, tag
// read, push; page-aligned free: answered without a tag read. Allocate from an
// empty class splits the spare page at one push per cycle on the single stack
// write port, pushing N chunks, N the chunks per page (255 for 16-byte chunks
// on a 4 KiB page). A result waiting on rsp_ready does not block the next request.
// Stack counts reset at once; no clearing pass is run.
module size_class_chunk_allocator_unit #(
  parameter int PAGE_BYTES  = 4096,
  parameter int HEAP_PAGES  = 64,
  parameter int CLASS_DEPTH = 1024
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      req_valid,
  output logic                     req_ready,
  input  wire scca_pkg::req_word_t req,
  output logic                     rsp_valid,
  input  wire                      rsp_ready,
  output scca_pkg::rsp_word_t      rsp
);
  import scca_pkg::*;

  localparam int IDX_W     = $clog2(CLASS_DEPTH);
  localparam int CNT_W     = $clog2(CLASS_DEPTH + 1);
  localparam int STK_AW    = CLS_W + IDX_W;
  localparam int STK_DEPTH = NUM_CLASSES << IDX_W;
  localparam int OFF_W     = $clog2(PAGE_BYTES + 1);
  localparam int Q_W       = ADDR_W - $clog2(PAGE_BYTES) + 1;
  localparam int PG_W      = (Q_W > 6) ? Q_W : 6;
  localparam int SLOT_N    = 1 << PG_W;
  localparam int TAG_AW    = (HEAP_PAGES > 1) ? $clog2(HEAP_PAGES) : 1;
  localparam int DIV_K     = ADDR_W + $clog2(PAGE_BYTES);
  localparam int M_W       = ADDR_W + 1;
  localparam int DP_W      = ADDR_W + M_W;
  localparam int PROD_W    = PG_W + OFF_W;
  localparam logic [63:0] DIV_M = ((64'd1 << DIV_K) + 64'(PAGE_BYTES) - 64'd1)
                                  / 64'(PAGE_BYTES);

  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_BIG       = 7'b0000010,
    S_DIV       = 7'b0000100,
    S_TAG       = 7'b0001000,
    S_POP       = 7'b0010000,
    S_SPLIT     = 7'b0100000,
    S_SPLIT_END = 7'b1000000
  } state_t;

  state_t state, state_next;

  logic [CNT_W-1:0]  counts [NUM_CLASSES];
  logic [CLS_W-1:0]  cls;
  logic [SZ_W-1:0]   sz;
  logic [ADDR_W-1:0] base;
  logic [OFF_W-1:0]  off;
  logic [ADDR_W-1:0] last_addr;
  logic [ADDR_W-1:0] a_reg;
  logic [PG_W-1:0]   q_reg;

  logic [ADDR_W-1:0] stk_mem [STK_DEPTH];
  logic [ADDR_W-1:0] stk_rd;
  logic              stk_we, stk_re;
  logic [STK_AW-1:0] stk_waddr, stk_raddr;
  logic [ADDR_W-1:0] stk_wdata;

  logic [CLS_W-1:0]  tag_mem [HEAP_PAGES];
  logic [CLS_W-1:0]  tag_rd;
  logic              tag_we, tag_re;
  logic [TAG_AW-1:0] tag_waddr, tag_raddr;

  logic [TAG_AW-1:0] slot_lut [SLOT_N];

  logic              accept, slot_free, emit;
  rsp_word_t         emit_word;
  logic              cnt_inc, cnt_dec;
  logic [CLS_W-1:0]  cnt_sel;
  logic [CLS_W-1:0]  req_cls, tag_cls;
  logic              too_big, aligned;
  logic [DP_W-1:0]   div_prod;
  logic [ADDR_W-1:0] split_addr;
  logic [PROD_W-1:0] spare_base, q_base;

  for (genvar i = 0; i < SLOT_N; i++) begin : g_slot
    assign slot_lut[i] = TAG_AW'(i % HEAP_PAGES);
  end

  assign req_ready  = (state == S_IDLE);
  assign accept     = req_valid && req_ready;
  assign slot_free  = !rsp_valid || rsp_ready;
  assign req_cls    = class_of(req.alloc_bytes);
  assign too_big    = req.alloc_bytes > MAX_CHUNK;
  assign div_prod   = DP_W'(req.free_addr) * DP_W'(DIV_M);
  assign spare_base = PROD_W'(req.spare_page) * PROD_W'(PAGE_BYTES);
  assign q_base     = PROD_W'(q_reg) * PROD_W'(PAGE_BYTES);
  assign aligned    = (q_base == PROD_W'(a_reg));
  assign split_addr = base + ADDR_W'(off);
  assign tag_cls    = (tag_rd >= CLS_W'(NUM_CLASSES)) ? '0 : tag_rd;
  assign stk_waddr  = {cnt_sel, counts[cnt_sel][IDX_W-1:0]};

  always_comb begin
    state_next = state;
    stk_we     = 1'b0;
    stk_wdata  = a_reg;
    stk_re     = 1'b0;
    stk_raddr  = {req_cls, IDX_W'(counts[req_cls] - CNT_W'(1))};
    tag_we     = 1'b0;
    tag_waddr  = slot_lut[PG_W'(req.spare_page)];
    tag_re     = 1'b0;
    tag_raddr  = slot_lut[q_reg];
    emit       = 1'b0;
    emit_word  = '0;
    cnt_inc    = 1'b0;
    cnt_dec    = 1'b0;
    cnt_sel    = cls;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          if (req.cmd == CMD_FREE) begin
            state_next = S_DIV;
          end else if (too_big) begin
            state_next = S_BIG;
          end else if (counts[req_cls] == '0) begin
            tag_we     = 1'b1;
            state_next = S_SPLIT;
          end else begin
            stk_re     = 1'b1;
            cnt_dec    = 1'b1;
            cnt_sel    = req_cls;
            state_next = S_POP;
          end
        end
      end
      S_BIG: begin
        if (slot_free) begin
          emit              = 1'b1;
          emit_word.status  = ST_TOO_LARGE;
          state_next        = S_IDLE;
        end
      end
      S_DIV: begin
        if (aligned) begin
          if (slot_free) begin
            emit             = 1'b1;
            emit_word.status = ST_PAGE_FREE;
            state_next       = S_IDLE;
          end
        end else begin
          tag_re     = 1'b1;
          state_next = S_TAG;
        end
      end
      S_TAG: begin
        cnt_sel = tag_cls;
        if (slot_free) begin
          emit                 = 1'b1;
          emit_word.size_class = tag_cls;
          state_next           = S_IDLE;
          if (counts[tag_cls] < CNT_W'(CLASS_DEPTH)) begin
            stk_we           = 1'b1;
            cnt_inc          = 1'b1;
            emit_word.status = ST_FREED;
          end else begin
            emit_word.status = ST_FULL;
          end
        end
      end
      S_POP: begin
        if (slot_free) begin
          emit                 = 1'b1;
          emit_word.status     = ST_GIVEN;
          emit_word.chunk_addr = stk_rd;
          emit_word.size_class = cls;
          state_next           = S_IDLE;
        end
      end
      S_SPLIT: begin
        stk_wdata = split_addr;
        if (counts[cls] < CNT_W'(CLASS_DEPTH)) begin
          stk_we  = 1'b1;
          cnt_inc = 1'b1;
        end
        if (off < OFF_W'(HDR_BYTES) + OFF_W'(sz)) begin
          state_next = S_SPLIT_END;
        end
      end
      S_SPLIT_END: begin
        if (slot_free) begin
          emit                 = 1'b1;
          cnt_dec              = 1'b1;
          emit_word.status     = ST_SPLIT;
          emit_word.chunk_addr = last_addr;
          emit_word.size_class = cls;
          state_next           = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        counts[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (emit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (cnt_inc) begin
        counts[cnt_sel] <= counts[cnt_sel] + CNT_W'(1);
      end else if (cnt_dec) begin
        counts[cnt_sel] <= counts[cnt_sel] - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      rsp <= emit_word;
    end
    if (accept) begin
      cls   <= req_cls;
      sz    <= CLASS_BYTES[req_cls];
      base  <= spare_base[ADDR_W-1:0];
      off   <= OFF_W'(PAGE_BYTES) - OFF_W'(CLASS_BYTES[req_cls]);
      a_reg <= req.free_addr;
      q_reg <= PG_W'(div_prod >> DIV_K);
    end else if (state == S_SPLIT) begin
      off <= off - OFF_W'(sz);
    end
    if (state == S_SPLIT && stk_we) begin
      last_addr <= split_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    if (stk_re) begin
      stk_rd <= stk_mem[stk_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem[tag_waddr] <= req_cls;
    end
    if (tag_re) begin
      tag_rd <= tag_mem[tag_raddr];
    end
  end

  a_one_word: assert property (@(posedge clk) disable iff (rst)
    accept |=> !req_ready)
    else $error("request taken while a word is in flight");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    cnt_inc |-> counts[cnt_sel] < CNT_W'(CLASS_DEPTH))
    else $error("push into a full class stack");

  a_split_off: assert property (@(posedge clk) disable iff (rst)
    state == S_SPLIT |-> off >= OFF_W'(HDR_BYTES))
    else $error("split chunk overlaps the page header");

  a_split_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == S_SPLIT_END |-> counts[cls] != '0)
    else $error("split left the class stack empty");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |-> !emit)
    else $error("result overwritten before it was taken");

endmodule

`default_nettype wire
